// ===== rtl/sga_pkg.sv =====
// sga_pkg: shared types, constants and binary32/binary16 arithmetic functions
// for the SiLU / tanh-GELU activation pipeline. No dependencies.
`timescale 1ns / 1ps
package sga_pkg;

  // Register index of the APB map (bit 2 of the byte address)
  localparam logic REG_IDX_MODE = 1'b0;

  // Activation select codes
  localparam logic MODE_SILU = 1'b0;
  localparam logic MODE_GELU = 1'b1;

  // Quotient bits produced by the divider: integer bit, 23 fraction, guard, two extra
  localparam int DIV_BITS = 27;

  localparam logic [31:0] F32_ONE    = 32'h3F80_0000;
  localparam logic [31:0] F32_TWO    = 32'h4000_0000;
  localparam logic [31:0] F32_HALF   = 32'h3F00_0000;
  localparam logic [31:0] F32_GELU_K = 32'h3F4C_422A;
  localparam logic [31:0] F32_GELU_C = 32'h3D37_2713;
  localparam logic [31:0] F32_LOG2E  = 32'h3FB8_AA3B;
  localparam logic [31:0] F32_LN2    = 32'h3F31_7218;
  localparam logic [30:0] F32_CLAMP  = 31'h42B0_0000;
  localparam logic [31:0] F32_C120   = 32'h3C08_8889;
  localparam logic [31:0] F32_C24    = 32'h3D2A_AAAB;
  localparam logic [31:0] F32_C6     = 32'h3E2A_AAAB;

  // One element in flight
  typedef struct packed {
    logic              vld;
    logic              mode;
    logic              spec;
    logic [15:0]       spec_val;
    logic [31:0]       x;
    logic [31:0]       a;
    logic signed [7:0] n;
    logic [31:0]       acc;
  } item_t;

  // Restoring divider state
  typedef struct packed {
    logic [24:0]        r;
    logic [23:0]        md;
    logic [26:0]        q;
    logic               sgn;
    logic signed [10:0] e;
    logic               zero;
  } div_t;

  // Round a significand {hidden, 23 frac, guard, sticky} with biased exponent e
  function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [10:0] e,
                                          input logic [25:0] m);
    logic [25:0] mm;
    logic [25:0] lost;
    logic [4:0]  sh;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    mm   = m;
    lost = '0;
    sh   = '0;
    ef   = '0;
    inc  = 1'b0;
    if (e >= 11'sd255) begin
      mag = {8'hFF, 23'd0};
    end else begin
      if (e < 11'sd1) begin
        if (e < -11'sd24) begin
          mm = {25'd0, |m};
        end else begin
          sh   = 5'(11'sd1 - e);
          lost = m & ((26'd1 << sh) - 26'd1);
          mm   = (m >> sh) | {25'd0, |lost};
        end
      end else begin
        ef = mm[25] ? e[7:0] : 8'd0;
      end
      inc = mm[1] & (mm[0] | mm[2]);
      mag = {ef, mm[24:2]} + {30'd0, inc};
    end
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sgn;
    logic [47:0]        p;
    logic signed [10:0] e;
    logic [25:0]        m;
    sgn = a[31] ^ b[31];
    p   = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    e   = 11'({3'd0, a[30:23]}) + 11'({3'd0, b[30:23]}) - 11'd127;
    if (p[47]) begin
      m = {p[47:23], |p[22:0]};
      e = e + 11'sd1;
    end else begin
      m = {p[46:22], |p[21:0]};
    end
    if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
      return {sgn, 31'd0};
    end
    return fp_pack(sgn, e, m);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        l;
    logic [31:0]        s;
    logic [7:0]         el;
    logic [7:0]         es;
    logic [7:0]         d;
    logic [23:0]        ml;
    logic [23:0]        ms;
    logic [26:0]        al;
    logic [26:0]        as0;
    logic [26:0]        as1;
    logic [26:0]        lost;
    logic [27:0]        sum;
    logic [26:0]        nm;
    logic [4:0]         lz;
    logic signed [10:0] e;
    logic signed [10:0] lim;
    logic               sub;
    if (a[30:0] >= b[30:0]) begin
      l = a;
      s = b;
    end else begin
      l = b;
      s = a;
    end
    el   = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
    es   = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
    ml   = {|l[30:23], l[22:0]};
    ms   = {|s[30:23], s[22:0]};
    d    = el - es;
    al   = {ml, 3'b000};
    as0  = {ms, 3'b000};
    lost = '0;
    if (d > 8'd26) begin
      as1 = {26'd0, |ms};
    end else begin
      lost = as0 & ((27'd1 << d) - 27'd1);
      as1  = (as0 >> d) | {26'd0, |lost};
    end
    sub = l[31] ^ s[31];
    sum = sub ? ({1'b0, al} - {1'b0, as1}) : ({1'b0, al} + {1'b0, as1});
    e   = 11'({3'd0, el});
    lz  = '0;
    if (sum == 28'd0) begin
      return {l[31] & s[31], 31'd0};
    end
    if (sum[27]) begin
      nm = {sum[27:2], |sum[1:0]};
      e  = e + 11'sd1;
    end else begin
      for (int i = 0; i < 27; i++) begin
        if (sum[i]) lz = 5'(26 - i);
      end
      lim = e - 11'sd1;
      // stop at the subnormal boundary
      if ($signed({6'd0, lz}) > lim) lz = 5'(lim);
      nm = sum[26:0] << lz;
      e  = e - $signed({6'd0, lz});
    end
    return fp_pack(l[31], e, {nm[26:2], |nm[1:0]});
  endfunction

  // Round to nearest integer, ties to even; |y| < 128
  function automatic logic signed [7:0] f32_round_int(input logic [31:0] y);
    logic [7:0]  ex;
    logic [23:0] mt;
    logic [4:0]  sh;
    logic [7:0]  ip;
    logic        rb;
    logic        st;
    logic [23:0] msk;
    ex = y[30:23];
    mt = {1'b1, y[22:0]};
    if (ex < 8'd126) begin
      return 8'sd0;
    end
    sh  = 5'(8'd150 - ex);
    ip  = 8'(mt >> sh);
    rb  = mt[sh - 5'd1];
    msk = (24'd1 << (sh - 5'd1)) - 24'd1;
    st  = |(mt & msk);
    ip  = ip + {7'd0, rb & (st | ip[0])};
    return y[31] ? $signed(8'd0 - ip) : $signed(ip);
  endfunction

  function automatic logic [31:0] int_to_f32(input logic signed [7:0] n);
    logic [6:0]  mg;
    logic [2:0]  k;
    logic [29:0] w;
    mg = n[7] ? 7'(8'd0 - n) : n[6:0];
    k  = '0;
    if (mg == 7'd0) begin
      return 32'd0;
    end
    for (int i = 0; i < 7; i++) begin
      if (mg[i]) k = 3'(i);
    end
    w = {23'd0, mg} << (5'd23 - {2'b00, k});
    return {n[7], 8'd127 + {5'd0, k}, w[22:0]};
  endfunction

  function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [32:0] w;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    k = '0;
    if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      for (int i = 0; i < 10; i++) begin
        if (m[i]) k = 4'(i);
      end
      w = {23'd0, m} << (5'd23 - {1'b0, k});
      return {s, 8'd103 + {4'd0, k}, w[22:0]};
    end
    if (e == 5'd31) return {s, 8'hFF, m, 13'd0};
    return {s, {3'd0, e} + 8'd112, m, 13'd0};
  endfunction

  function automatic logic [15:0] f32_to_f16(input logic [31:0] v);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] mm;
    logic [7:0]  sh8;
    logic [4:0]  sh;
    logic [14:0] q;
    logic [23:0] rem;
    logic [23:0] hlf;
    logic [12:0] r13;
    s = v[31];
    e = v[30:23];
    m = v[22:0];
    if (e == 8'hFF) return {s, 5'h1F, (m != 23'd0) ? (10'h200 | m[22:13]) : 10'd0};
    if (e == 8'd0) return {s, 15'd0};
    if (e >= 8'd143) return {s, 15'h7C00};
    if (e <= 8'd112) begin
      mm  = {1'b1, m};
      sh8 = 8'd126 - e;
      if (sh8 >= 8'd25) return {s, 15'd0};
      sh  = sh8[4:0];
      q   = 15'(mm >> sh);
      rem = mm & ((24'd1 << sh) - 24'd1);
      hlf = 24'd1 << (sh - 5'd1);
      if (rem > hlf || (rem == hlf && q[0])) q = q + 15'd1;
      return {s, q};
    end
    q   = {5'(e - 8'd112), m[22:13]};
    r13 = m[12:0];
    if (r13 > 13'h1000 || (r13 == 13'h1000 && q[0])) q = q + 15'd1;
    return {s, q};
  endfunction

  function automatic div_t div_prep(input logic [31:0] num, input logic [31:0] den);
    div_t dv;
    dv.sgn  = num[31] ^ den[31];
    dv.zero = (num[30:23] == 8'd0);
    dv.e    = 11'({3'd0, num[30:23]}) - 11'({3'd0, den[30:23]}) + 11'd127;
    dv.r    = {2'b01, num[22:0]};
    dv.md   = {1'b1, den[22:0]};
    dv.q    = '0;
    return dv;
  endfunction

  function automatic div_t div_step(input div_t di);
    div_t        dv;
    logic [24:0] r2;
    logic        qb;
    dv = di;
    qb = (di.r >= {1'b0, di.md});
    r2 = qb ? (di.r - {1'b0, di.md}) : di.r;
    dv.q = {di.q[25:0], qb};
    dv.r = {r2[23:0], 1'b0};
    return dv;
  endfunction

  function automatic logic [31:0] div_pack(input div_t dv);
    logic        st;
    logic [25:0] m;
    logic signed [10:0] e;
    st = (dv.r != 25'd0);
    e  = dv.e;
    if (dv.q[26]) begin
      m = {dv.q[26:2], dv.q[1] | dv.q[0] | st};
    end else begin
      m = {dv.q[25:1], dv.q[0] | st};
      e = e - 11'sd1;
    end
    if (dv.zero) return {dv.sgn, 31'd0};
    return fp_pack(dv.sgn, e, m);
  endfunction

endpackage

// ===== rtl/silu_gelu_activation.sv =====
// Throughput: one element per cycle while the output is not stalled; each stage
// holds at most one fp32 multiply or add, and the divider retires one quotient bit
// per stage over 27 stages.
// A stalled output freezes the whole pipeline in place; nothing is dropped.
// Reset clears the mode register (SiLU) and every stage valid bit.
`timescale 1ns / 1ps
module silu_gelu_activation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] value_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           mode_q;
  logic           en;
  logic           cfg_wr;
  sga_pkg::item_t in_d;
  sga_pkg::item_t in_q;
  sga_pkg::item_t poly_o;
  sga_pkg::item_t exp_o;
  sga_pkg::item_t div_o;
  sga_pkg::item_t post_o;
  logic           out_valid_q;
  logic [15:0]    out_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == sga_pkg::REG_IDX_MODE);
  assign prdata = (paddr[2] == sga_pkg::REG_IDX_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sga_pkg::MODE_SILU;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  // Advance all stages whenever the output slot is free or being taken
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    in_d          = '0;
    in_d.vld      = in_valid_i;
    in_d.mode     = mode_q;
    in_d.x        = sga_pkg::f16_to_f32(value_in_i);
    if (value_in_i[14:0] > 15'h7C00) begin
      in_d.spec     = 1'b1;
      in_d.spec_val = value_in_i | 16'h0200;
      in_d.x        = '0;
    end else if (value_in_i[14:0] == 15'h7C00) begin
      in_d.spec     = 1'b1;
      in_d.spec_val = value_in_i[15] ? 16'h8000 : 16'h7C00;
      in_d.x        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q <= in_d;
    end
  end

  sga_poly u_poly (.clk_i, .rst_ni, .en_i(en), .item_i(in_q),   .item_o(poly_o));
  sga_exp  u_exp  (.clk_i, .rst_ni, .en_i(en), .item_i(poly_o), .item_o(exp_o));
  sga_div  u_div  (.clk_i, .rst_ni, .en_i(en), .item_i(exp_o),  .item_o(div_o));
  sga_post u_post (.clk_i, .rst_ni, .en_i(en), .item_i(div_o),  .item_o(post_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= post_o.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= post_o.spec ? post_o.spec_val : sga_pkg::f32_to_f16(post_o.acc);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_q;

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (mode_q == $past(pwdata[0])))
    else $error("mode register did not take the written value");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(post_o))
    else $error("pipeline moved while the output was stalled");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(post_o.vld))
    else $error("output valid without a transaction in the last stage");

endmodule

// ===== rtl/sga_poly.sv =====
// sga_poly: GELU front end, cubic term and tanh argument, one fp32 op per stage.
// Depends on sga_pkg.
`timescale 1ns / 1ps
module sga_poly (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  sga_pkg::item_t item_i,
  output sga_pkg::item_t item_o
);

  localparam int NS = 6;

  sga_pkg::item_t st_q [NS];
  sga_pkg::item_t st_d [NS];

  always_comb begin
    st_d[0]     = item_i;
    st_d[0].acc = sga_pkg::fp_mul(item_i.x, item_i.x);
    st_d[1]     = st_q[0];
    st_d[1].acc = sga_pkg::fp_mul(st_q[0].x, st_q[0].acc);
    st_d[2]     = st_q[1];
    st_d[2].acc = sga_pkg::fp_mul(sga_pkg::F32_GELU_C, st_q[1].acc);
    st_d[3]     = st_q[2];
    st_d[3].acc = sga_pkg::fp_add(st_q[2].x, st_q[2].acc);
    st_d[4]     = st_q[3];
    st_d[4].acc = sga_pkg::fp_mul(sga_pkg::F32_GELU_K, st_q[3].acc);
    // exp argument: 2*inner for GELU, -x for SiLU
    st_d[5]     = st_q[4];
    st_d[5].a   = (st_q[4].mode == sga_pkg::MODE_GELU) ?
                  sga_pkg::fp_mul(st_q[4].acc, sga_pkg::F32_TWO) :
                  {~st_q[4].x[31], st_q[4].x[30:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{default: '0};
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign item_o = st_q[NS-1];

endmodule

// ===== rtl/sga_exp.sv =====
// sga_exp: exp approximation (clamp, range reduction, degree-5 Horner, 2^n scale)
// followed by 1 + exp. Depends on sga_pkg.
`timescale 1ns / 1ps
module sga_exp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  sga_pkg::item_t item_i,
  output sga_pkg::item_t item_o
);

  localparam int NS = 16;

  sga_pkg::item_t st_q [NS];
  sga_pkg::item_t st_d [NS];
  logic [31:0]    a_clamp;

  always_comb begin
    a_clamp = (item_i.a[30:0] > sga_pkg::F32_CLAMP) ?
              {item_i.a[31], sga_pkg::F32_CLAMP} : item_i.a;

    st_d[0]     = item_i;
    st_d[0].a   = a_clamp;
    st_d[0].acc = sga_pkg::fp_mul(a_clamp, sga_pkg::F32_LOG2E);
    st_d[1]     = st_q[0];
    st_d[1].n   = sga_pkg::f32_round_int(st_q[0].acc);
    st_d[1].acc = sga_pkg::int_to_f32(sga_pkg::f32_round_int(st_q[0].acc));
    st_d[2]     = st_q[1];
    st_d[2].acc = sga_pkg::fp_mul(st_q[1].acc, sga_pkg::F32_LN2);
    // reduced argument f replaces a from here on
    st_d[3]     = st_q[2];
    st_d[3].a   = sga_pkg::fp_add(st_q[2].a, {~st_q[2].acc[31], st_q[2].acc[30:0]});
    st_d[4]     = st_q[3];
    st_d[4].acc = sga_pkg::fp_mul(sga_pkg::F32_C120, st_q[3].a);
    st_d[5]     = st_q[4];
    st_d[5].acc = sga_pkg::fp_add(sga_pkg::F32_C24, st_q[4].acc);
    st_d[6]     = st_q[5];
    st_d[6].acc = sga_pkg::fp_mul(st_q[5].acc, st_q[5].a);
    st_d[7]     = st_q[6];
    st_d[7].acc = sga_pkg::fp_add(sga_pkg::F32_C6, st_q[6].acc);
    st_d[8]     = st_q[7];
    st_d[8].acc = sga_pkg::fp_mul(st_q[7].acc, st_q[7].a);
    st_d[9]     = st_q[8];
    st_d[9].acc = sga_pkg::fp_add(sga_pkg::F32_HALF, st_q[8].acc);
    st_d[10]     = st_q[9];
    st_d[10].acc = sga_pkg::fp_mul(st_q[9].acc, st_q[9].a);
    st_d[11]     = st_q[10];
    st_d[11].acc = sga_pkg::fp_add(sga_pkg::F32_ONE, st_q[10].acc);
    st_d[12]     = st_q[11];
    st_d[12].acc = sga_pkg::fp_mul(st_q[11].acc, st_q[11].a);
    st_d[13]     = st_q[12];
    st_d[13].acc = sga_pkg::fp_add(sga_pkg::F32_ONE, st_q[12].acc);
    // scale by 2^n built from the exponent field; n = -127 gives zero
    st_d[14]     = st_q[13];
    st_d[14].acc = sga_pkg::fp_mul(st_q[13].acc,
                                   {1'b0, 8'(st_q[13].n + 8'sd127), 23'd0});
    st_d[15]     = st_q[14];
    st_d[15].acc = sga_pkg::fp_add(sga_pkg::F32_ONE, st_q[14].acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{default: '0};
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign item_o = st_q[NS-1];

endmodule

// ===== rtl/sga_div.sv =====
// sga_div: pipelined restoring fp32 divider, one quotient bit per stage.
// Computes x/d for SiLU and 2/d for GELU. Depends on sga_pkg.
`timescale 1ns / 1ps
module sga_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  sga_pkg::item_t item_i,
  output sga_pkg::item_t item_o
);

  localparam int NDV = sga_pkg::DIV_BITS + 1;
  localparam int NS  = NDV + 1;

  sga_pkg::item_t it_q [NS];
  sga_pkg::item_t it_d [NS];
  sga_pkg::div_t  dv_q [NDV];
  sga_pkg::div_t  dv_d [NDV];

  always_comb begin
    it_d[0] = item_i;
    dv_d[0] = sga_pkg::div_prep((item_i.mode == sga_pkg::MODE_GELU) ?
                                sga_pkg::F32_TWO : item_i.x, item_i.acc);
    for (int g = 1; g < NDV; g++) begin
      it_d[g] = it_q[g-1];
      dv_d[g] = sga_pkg::div_step(dv_q[g-1]);
    end
    it_d[NS-1]     = it_q[NS-2];
    it_d[NS-1].acc = sga_pkg::div_pack(dv_q[NDV-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '{default: '0};
      dv_q <= '{default: '0};
    end else if (en_i) begin
      it_q <= it_d;
      dv_q <= dv_d;
    end
  end

  assign item_o = it_q[NS-1];

endmodule

// ===== rtl/sga_post.sv =====
// sga_post: GELU back end, 1 - q, 1 + tanh, x * (1 + tanh), halving; SiLU passes q.
// Depends on sga_pkg.
`timescale 1ns / 1ps
module sga_post (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  sga_pkg::item_t item_i,
  output sga_pkg::item_t item_o
);

  localparam int NS = 4;

  sga_pkg::item_t st_q [NS];
  sga_pkg::item_t st_d [NS];

  always_comb begin
    // keep the quotient in a for the SiLU result
    st_d[0]     = item_i;
    st_d[0].a   = item_i.acc;
    st_d[0].acc = sga_pkg::fp_add(sga_pkg::F32_ONE, {~item_i.acc[31], item_i.acc[30:0]});
    st_d[1]     = st_q[0];
    st_d[1].acc = sga_pkg::fp_add(sga_pkg::F32_ONE, st_q[0].acc);
    st_d[2]     = st_q[1];
    st_d[2].acc = sga_pkg::fp_mul(st_q[1].x, st_q[1].acc);
    st_d[3]     = st_q[2];
    st_d[3].acc = (st_q[2].mode == sga_pkg::MODE_GELU) ?
                  sga_pkg::fp_mul(sga_pkg::F32_HALF, st_q[2].acc) : st_q[2].a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{default: '0};
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign item_o = st_q[NS-1];

endmodule

// ===== test/tb_silu_gelu_activation.sv =====
// Testbench for silu_gelu_activation: streams binary16 elements through the
// block in SiLU and GELU mode and checks every result against a bit-exact fp32 model.
// Depends on sga_pkg (register index and mode codes) and the RTL top level.
`timescale 1ns / 1ps
module tb_silu_gelu_activation;

  localparam logic [31:0] SP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] SP_TWO   = 32'h4000_0000;
  localparam logic [31:0] SP_HALF  = 32'h3F00_0000;
  localparam logic [31:0] SP_K     = 32'h3F4C_422A;
  localparam logic [31:0] SP_C     = 32'h3D37_2713;
  localparam logic [31:0] SP_LOG2E = 32'h3FB8_AA3B;
  localparam logic [31:0] SP_LN2   = 32'h3F31_7218;
  localparam logic [31:0] SP_C120  = 32'h3C08_8889;
  localparam logic [31:0] SP_C24   = 32'h3D2A_AAAB;
  localparam logic [31:0] SP_C6    = 32'h3E2A_AAAB;
  localparam logic [30:0] SP_CLAMP = 31'h42B0_0000;
  localparam logic [2:0]  MODE_ADDR = {sga_pkg::REG_IDX_MODE, 2'b00};
  localparam int          DRAIN_CYCLES = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] value_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] value_out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] expected_values[$];
  logic        cur_mode;
  int          fail_count;
  int          burst_left;

  silu_gelu_activation dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------- fp32 / fp16 model ----------------

  // Round m * 2^e (plus sticky) to a binary format with fb fraction bits.
  function automatic logic [31:0] fp_round(input logic s, input int e, input logic [79:0] m,
                                           input logic st, input int fb, input int bias,
                                           input int emax);
    int          p;
    int          q;
    int          sh;
    int          ex;
    int          sp;
    logic [80:0] kept;
    logic        rb;
    logic        lo;
    logic        up;
    sp = (fb == 23) ? 31 : 15;
    p  = -1;
    for (int i = 0; i < 80; i++) if (m[i]) p = i;
    if (p < 0) return 32'(s) << sp;
    q = p + e - fb;
    if (q < 1 - bias - fb) q = 1 - bias - fb;
    sh = q - e;
    up = 1'b0;
    if (sh > 80) begin
      kept = '0;
    end else if (sh > 0) begin
      kept = {1'b0, m} >> sh;
      rb   = m[sh-1];
      lo   = st | ((m & ((80'd1 << (sh - 1)) - 80'd1)) != 80'd0);
      up   = rb & (lo | kept[0]);
    end else begin
      kept = {1'b0, m} << (-sh);
    end
    kept = kept + 81'(up);
    if (kept[fb+1]) begin
      kept = kept >> 1;
      q++;
    end
    if (kept[fb]) begin
      ex = q + fb + bias;
      if (ex >= emax) return (32'(s) << sp) | (32'(emax) << fb);
      return (32'(s) << sp) | (32'(ex) << fb) | (32'(kept) & ((32'd1 << fb) - 32'd1));
    end
    return (32'(s) << sp) | 32'(kept);
  endfunction

  function automatic void sp_split(input logic [31:0] b, output logic s, output int e,
                                   output logic [79:0] m);
    s = b[31];
    if (b[30:23] == 8'd0) begin
      m = {57'd0, b[22:0]};
      e = -149;
    end else begin
      m = {56'd0, 1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] sp_neg(input logic [31:0] b);
    return {~b[31], b[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb;
    int          ea, eb;
    logic [79:0] ma, mb;
    sp_split(a, sa, ea, ma);
    sp_split(b, sb, eb, mb);
    if (ma == 80'd0 || mb == 80'd0) return {sa ^ sb, 31'd0};
    return fp_round(sa ^ sb, ea + eb, ma * mb, 1'b0, 23, 127, 255);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, sl, ss, sr;
    int          ea, eb, el, es, d, er;
    logic [79:0] ma, mb, ml, ms, big, sml, mr;
    sp_split(a, sa, ea, ma);
    sp_split(b, sb, eb, mb);
    if (ma == 80'd0 && mb == 80'd0) return {sa & sb, 31'd0};
    if (ma == 80'd0) return b;
    if (mb == 80'd0) return a;
    if (ea >= eb) begin
      sl = sa; el = ea; ml = ma; ss = sb; es = eb; ms = mb;
    end else begin
      sl = sb; el = eb; ml = mb; ss = sa; es = ea; ms = ma;
    end
    d = el - es;
    if (d >= 40) begin
      // the smaller operand only decides the side of the rounding point
      big = ml << 40;
      sml = 80'd1;
      er  = el - 40;
    end else begin
      big = ml << d;
      sml = ms;
      er  = es;
    end
    if (sl == ss) begin
      mr = big + sml;
      sr = sl;
    end else if (big >= sml) begin
      mr = big - sml;
      sr = sl;
    end else begin
      mr = sml - big;
      sr = ss;
    end
    if (mr == 80'd0) return 32'd0;
    return fp_round(sr, er, mr, 1'b0, 23, 127, 255);
  endfunction

  function automatic logic [31:0] sp_div(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb;
    int          ea, eb;
    logic [79:0] ma, mb, quo, rem;
    sp_split(a, sa, ea, ma);
    sp_split(b, sb, eb, mb);
    if (ma == 80'd0) return {sa ^ sb, 31'd0};
    quo = (ma << 48) / mb;
    rem = (ma << 48) % mb;
    return fp_round(sa ^ sb, ea - eb - 48, quo, rem != 80'd0, 23, 127, 255);
  endfunction

  function automatic int nearest_int(input logic [31:0] y);
    logic        s;
    int          e;
    int          sh;
    logic [79:0] m;
    logic [79:0] ip;
    logic        rb;
    logic        st;
    sp_split(y, s, e, m);
    sh = -e;
    if (sh > 80) begin
      ip = '0;
    end else begin
      ip = m >> sh;
      rb = m[sh-1];
      st = (m & ((80'd1 << (sh - 1)) - 80'd1)) != 80'd0;
      ip = ip + 80'(rb & (st | ip[0]));
    end
    return s ? -int'(ip) : int'(ip);
  endfunction

  function automatic logic [31:0] exp_est(input logic [31:0] a);
    logic [31:0] y, fn, f, p;
    int          n;
    if (a[30:0] > SP_CLAMP) a = {a[31], SP_CLAMP};
    y  = sp_mul(a, SP_LOG2E);
    n  = nearest_int(y);
    fn = fp_round(n < 0, 0, 80'(n < 0 ? -n : n), 1'b0, 23, 127, 255);
    f  = sp_add(a, sp_neg(sp_mul(fn, SP_LN2)));
    p  = SP_C120;
    p  = sp_add(SP_C24, sp_mul(p, f));
    p  = sp_add(SP_C6, sp_mul(p, f));
    p  = sp_add(SP_HALF, sp_mul(p, f));
    p  = sp_add(SP_ONE, sp_mul(p, f));
    p  = sp_add(SP_ONE, sp_mul(p, f));
    // n = -127 gives an all-zero scale factor
    return sp_mul(p, 32'(n + 127) << 23);
  endfunction

  function automatic logic [31:0] tanh_est(input logic [31:0] t);
    logic [31:0] d;
    d = sp_add(exp_est(sp_mul(t, SP_TWO)), SP_ONE);
    return sp_add(SP_ONE, sp_neg(sp_div(SP_TWO, d)));
  endfunction

  function automatic logic [15:0] activation_result(input logic [15:0] h, input logic mode);
    logic        s;
    int          e;
    logic [79:0] m;
    logic [31:0] x, r, inner;
    if (h[14:0] > 15'h7C00) return h | 16'h0200;
    if (h[14:0] == 15'h7C00) return h[15] ? 16'h8000 : 16'h7C00;
    if (h[14:10] == 5'd0) begin
      m = {70'd0, h[9:0]};
      e = -24;
    end else begin
      m = {69'd0, 1'b1, h[9:0]};
      e = int'(h[14:10]) - 25;
    end
    x = fp_round(h[15], e, m, 1'b0, 23, 127, 255);
    if (mode == sga_pkg::MODE_GELU) begin
      inner = sp_mul(SP_C, sp_mul(x, sp_mul(x, x)));
      inner = sp_mul(SP_K, sp_add(x, inner));
      r = sp_mul(SP_HALF, sp_mul(x, sp_add(SP_ONE, tanh_est(inner))));
    end else begin
      r = sp_div(x, sp_add(SP_ONE, exp_est(sp_neg(x))));
    end
    sp_split(r, s, e, m);
    return 16'(fp_round(s, e, m, 1'b0, 10, 15, 31));
  endfunction

  // ---------------- drivers ----------------

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == MODE_ADDR) cur_mode = data[0];
  endtask

  task automatic apb_check_mode();
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= MODE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'd0, cur_mode}) begin
      $error("activation_mode: expected %0h, got %0h", {31'd0, cur_mode}, got);
      fail_count++;
    end
  endtask

  task automatic send_value(input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    value_in_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    expected_values.push_back(activation_result(v, cur_mode));
    burst_left--;
  endtask

  // drop valid and wait until the pipeline has emptied
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return {1'($urandom), 5'($urandom_range(8, 19)), 10'($urandom)};
    if (r < 75) return 16'($urandom);
    if (r < 85) return {1'($urandom), 5'd0, 10'($urandom)};
    if (r < 93) return {1'($urandom), 5'($urandom_range(20, 30)), 10'($urandom)};
    return {1'($urandom), 5'h1F, 10'($urandom)};
  endfunction

  // ---------------- tests ----------------

  task automatic test_edge_values();
    logic [15:0] vals[$];
    vals = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF, 16'h83FF, 16'h0400,
             16'h3C00, 16'hBC00, 16'h3800, 16'hC000, 16'h4900, 16'hC900, 16'h5640,
             16'hD640, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01,
             16'hFE00, 16'hFC01, 16'h7FFF};
    foreach (vals[i]) send_value(vals[i]);
    drain();
  endtask

  task automatic test_set_mode(input logic mode);
    apb_write(MODE_ADDR, {$urandom} & 32'hFFFF_FFFE | {31'd0, mode});
    apb_check_mode();
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_value(random_half());
    drain();
  endtask

  // receiver: stall rate changes from segment to segment, some with no stalls
  int seg_left = 0;
  int stall_pct = 0;
  always @(posedge clk_i) begin
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 200);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    seg_left--;
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_values.size() == 0) begin
        $error("value_out: no result expected, got %04h", value_out_o);
        fail_count++;
      end else begin
        if (value_out_o !== expected_values[0]) begin
          $error("value_out: expected %04h, got %04h", expected_values[0], value_out_o);
          fail_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  initial begin
    #400000;
    $display("tb_silu_gelu_activation NOT OK");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    value_in_i  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cur_mode    = sga_pkg::MODE_SILU;
    fail_count  = 0;
    burst_left  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    apb_check_mode();
    test_edge_values();
    test_set_mode(sga_pkg::MODE_GELU);
    test_edge_values();
    test_random_stream(180);
    test_set_mode(sga_pkg::MODE_SILU);
    test_random_stream(180);
    test_set_mode(sga_pkg::MODE_GELU);
    test_random_stream(190);

    if (expected_values.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb_silu_gelu_activation OK");
    end else begin
      $display("tb_silu_gelu_activation NOT OK");
    end
    $finish;
  end

endmodule
